/* src/eave_pkg.sv */
package eave_pkg;

    localparam int ANGLE_BITS = 12;
    localparam int ANG_W = ANGLE_BITS + 1;
    localparam int DIFF_W = ANGLE_BITS + 2;
    localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(1) << ANGLE_BITS;
    localparam int HIST_DEPTH_DEF = 64;

    localparam int US_PER_S = 1000000;
    localparam int RATE_SCALE = 256 * US_PER_S;
    localparam int NUM_W = 41;
    localparam int DIV_STEPS = NUM_W;
    localparam int ALPHA_W = 17;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
    localparam int BLEND_STEPS = ALPHA_W;
    localparam int STEP_W = 6;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] raw_angle;
        logic [31:0]           timestamp_us;
    } in_word_t;

    typedef struct packed {
        logic [ANG_W-1:0]   angle;
        logic signed [31:0] velocity;
    } out_word_t;

    typedef struct packed {
        logic [11:0]        zero_offset;
        logic               reverse_direction;
        logic [12:0]        carry_threshold;
        logic [19:0]        max_speed;
        logic [19:0]        window_us;
        logic [ALPHA_W-1:0] smoothing_alpha;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic spk_mul;
        logic base_self;
        logic walk_rd;
        logic walk_chk;
        logic rate_mul;
        logic div_prep;
        logic div_step;
        logic blend_prep;
        logic blend_step;
        logic finish;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic hist_empty;
        logic spike;
        logic expired;
        logic last_entry;
        logic out_free;
    } sts_t;

    // delta across zero taken as a wrap of one turn
    function automatic logic signed [DIFF_W-1:0] unwrap(
        input logic signed [DIFF_W-1:0] d,
        input logic [12:0]              thr
    );
        logic [DIFF_W-1:0] mag;
        logic signed [DIFF_W-1:0] r;
        mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        r = d;
        if (mag > DIFF_W'(thr)) begin
            if (d > 0) r = d - $signed({1'b0, FULL_TURN});
            else       r = d + $signed({1'b0, FULL_TURN});
        end
        return r;
    endfunction

endpackage

/* src/encoder_angle_velocity_estimator.sv */
// channel   direction  word type              handshake
// s_        in         eave_pkg::in_word_t    s_valid / s_ready
// m_        out        eave_pkg::out_word_t   m_valid / m_ready
// apb       in         32-bit registers       psel / penable / pwrite, pready high
//
// one word in flight at a time; each word passes through the serial divider
// (41 steps), the serial blend multiplier (17 steps) and the history walk, which
// reads no entry on an empty history, else one more than the entries that
// expire, at most the entries held
// a word that fails the spike test is dropped in the spike compare state with no result
// reset clears state and the history count; history memory needs no clearing
// a new word is taken while the previous result still waits on m_ready
module encoder_angle_velocity_estimator #(
    parameter int HISTORY_DEPTH = eave_pkg::HIST_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input words
    input  logic                s_valid,
    output logic                s_ready,
    input  eave_pkg::in_word_t  s_data,
    // result words
    output logic                m_valid,
    input  logic                m_ready,
    output eave_pkg::out_word_t m_data,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    eave_pkg::cfg_t cfg;
    eave_pkg::cmd_t cmd;
    eave_pkg::sts_t sts;

    // configuration registers
    eave_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: spike test, history walk, divide, blend, deliver
    eave_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // arithmetic, history ring and output register
    eave_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule

/* src/eave_cfg.sv */
module eave_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output eave_pkg::cfg_t      cfg
);
    typedef enum logic [2:0] {
        REG_ZERO_OFFSET = 3'd0,
        REG_REVERSE     = 3'd1,
        REG_CARRY       = 3'd2,
        REG_MAX_SPEED   = 3'd3,
        REG_WINDOW      = 3'd4,
        REG_ALPHA       = 3'd5
    } reg_idx_t;

    eave_pkg::cfg_t cfg_reg;
    logic [2:0] idx;
    logic wr_en;

    assign idx = paddr[4:2];
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_offset       <= 12'd0;
            cfg_reg.reverse_direction <= 1'b1;
            cfg_reg.carry_threshold   <= 13'd3686;
            cfg_reg.max_speed         <= 20'd20480;
            cfg_reg.window_us         <= 20'd20000;
            cfg_reg.smoothing_alpha   <= 17'd55706;
        end else if (wr_en) begin
            unique case (idx)
                REG_ZERO_OFFSET: cfg_reg.zero_offset       <= pwdata[11:0];
                REG_REVERSE:     cfg_reg.reverse_direction <= pwdata[0];
                REG_CARRY:       cfg_reg.carry_threshold   <= pwdata[12:0];
                REG_MAX_SPEED:   cfg_reg.max_speed         <= pwdata[19:0];
                REG_WINDOW:      cfg_reg.window_us         <= pwdata[19:0];
                REG_ALPHA:       cfg_reg.smoothing_alpha   <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ZERO_OFFSET: prdata = {20'd0, cfg_reg.zero_offset};
            REG_REVERSE:     prdata = {31'd0, cfg_reg.reverse_direction};
            REG_CARRY:       prdata = {19'd0, cfg_reg.carry_threshold};
            REG_MAX_SPEED:   prdata = {12'd0, cfg_reg.max_speed};
            REG_WINDOW:      prdata = {12'd0, cfg_reg.window_us};
            REG_ALPHA:       prdata = {15'd0, cfg_reg.smoothing_alpha};
            default:         prdata = 32'd0;
        endcase
    end
endmodule

/* src/eave_ctrl.sv */
module eave_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  eave_pkg::sts_t sts,
    output eave_pkg::cmd_t cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_SPK_MUL, ST_SPK_CMP, ST_WALK_RD, ST_WALK_CHK, ST_RATE_MUL,
        ST_DIV_PREP, ST_DIV, ST_BLEND_PREP, ST_BLEND, ST_FINISH, ST_OUTPUT
    } state_t;

    state_t state_reg;
    logic [eave_pkg::STEP_W-1:0] step_reg;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE:     if (s_valid) state_reg <= ST_SPK_MUL;
                ST_SPK_MUL:  state_reg <= ST_SPK_CMP;
                ST_SPK_CMP: begin
                    priority if (sts.spike)      state_reg <= ST_IDLE;
                    else if (sts.hist_empty)     state_reg <= ST_RATE_MUL;
                    else                         state_reg <= ST_WALK_RD;
                end
                ST_WALK_RD:  state_reg <= ST_WALK_CHK;
                ST_WALK_CHK: begin
                    if (sts.expired && !sts.last_entry) state_reg <= ST_WALK_RD;
                    else                                state_reg <= ST_RATE_MUL;
                end
                ST_RATE_MUL: state_reg <= ST_DIV_PREP;
                ST_DIV_PREP: begin
                    state_reg <= ST_DIV;
                    step_reg  <= '0;
                end
                ST_DIV: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == eave_pkg::STEP_W'(eave_pkg::DIV_STEPS - 1))
                        state_reg <= ST_BLEND_PREP;
                end
                ST_BLEND_PREP: begin
                    state_reg <= ST_BLEND;
                    step_reg  <= '0;
                end
                ST_BLEND: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == eave_pkg::STEP_W'(eave_pkg::BLEND_STEPS - 1))
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:   state_reg <= ST_OUTPUT;
                ST_OUTPUT:   if (sts.out_free) state_reg <= ST_IDLE;
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd = '0;
        cmd.load       = (state_reg == ST_IDLE) && s_valid;
        cmd.spk_mul    = (state_reg == ST_SPK_MUL);
        cmd.base_self  = (state_reg == ST_SPK_CMP) && sts.hist_empty;
        cmd.walk_rd    = (state_reg == ST_WALK_RD);
        cmd.walk_chk   = (state_reg == ST_WALK_CHK);
        cmd.rate_mul   = (state_reg == ST_RATE_MUL);
        cmd.div_prep   = (state_reg == ST_DIV_PREP);
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.blend_prep = (state_reg == ST_BLEND_PREP);
        cmd.blend_step = (state_reg == ST_BLEND);
        cmd.finish     = (state_reg == ST_FINISH);
        cmd.commit     = (state_reg == ST_OUTPUT) && sts.out_free;
    end
endmodule

/* src/eave_dp.sv */
module eave_dp #(
    parameter int HISTORY_DEPTH = eave_pkg::HIST_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  eave_pkg::cfg_t      cfg,
    input  eave_pkg::cmd_t      cmd,
    output eave_pkg::sts_t      sts,
    input  eave_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output eave_pkg::out_word_t m_data
);
    localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int AW = eave_pkg::ANG_W;
    localparam int DW = eave_pkg::DIFF_W;
    localparam int NW = eave_pkg::NUM_W;

    logic [31:0]   hist_time  [HISTORY_DEPTH];
    logic [AW-1:0] hist_angle [HISTORY_DEPTH];

    logic [AW-1:0] a_reg, last_angle_reg, base_angle_reg, rd_angle_reg;
    logic [31:0]   t_reg, last_time_reg, base_time_reg, rd_time_reg, dt_reg;
    logic signed [31:0] last_vel_reg, vel_reg;
    logic [HW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [33:0]   prod_move_reg;
    logic [51:0]   prod_lim_reg;
    logic          neg_reg, zero_reg;
    logic [NW-1:0] num_reg;
    logic [32:0]   rem_reg;
    logic signed [NW+1:0] diff_reg;
    logic [eave_pkg::ALPHA_W-1:0] alpha_reg;
    logic signed [60:0] acc_reg;
    logic          m_valid_reg;
    eave_pkg::out_word_t m_data_reg;

    // input correction
    logic [eave_pkg::ANGLE_BITS-1:0] a_mod;
    logic [AW-1:0] a_new;
    assign a_mod = s_data.raw_angle - cfg.zero_offset[eave_pkg::ANGLE_BITS-1:0];
    assign a_new = cfg.reverse_direction ? (eave_pkg::FULL_TURN - AW'(a_mod)) : AW'(a_mod);

    // step against last sample and against the history base
    logic signed [DW-1:0] d_last, d_base;
    logic [DW-1:0] dmag_last, dmag_base;
    logic [31:0] dt_last, dt_base;
    assign d_last = eave_pkg::unwrap($signed({1'b0, a_reg}) - $signed({1'b0, last_angle_reg}),
                                     cfg.carry_threshold);
    assign dmag_last = d_last[DW-1] ? DW'(-d_last) : DW'(d_last);
    assign dt_last = t_reg - last_time_reg;
    assign d_base = eave_pkg::unwrap($signed({1'b0, a_reg}) - $signed({1'b0, base_angle_reg}),
                                     cfg.carry_threshold);
    assign dmag_base = d_base[DW-1] ? DW'(-d_base) : DW'(d_base);
    assign dt_base = t_reg - base_time_reg;

    // divider step
    logic [32:0] rem_sh;
    logic q_bit;
    assign rem_sh = {rem_reg[31:0], num_reg[NW-1]};
    assign q_bit = (rem_sh >= {1'b0, dt_reg});

    // signed rate
    logic signed [NW:0] rate;
    always_comb begin
        if (dt_reg == 32'd0) begin
            priority if (zero_reg) rate = '0;
            else if (neg_reg)      rate = (NW+1)'(-64'sd2147483648);
            else                   rate = (NW+1)'(64'sd2147483647);
        end else begin
            rate = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
        end
    end

    // rounding and saturation of the blend
    logic signed [61:0] sum;
    logic [61:0] sum_mag, sum_rnd;
    logic [45:0] q_mag;
    logic signed [31:0] vel_sat;
    always_comb begin
        sum = 62'(acc_reg) + (62'(last_vel_reg) <<< 16);
        sum_mag = sum[61] ? 62'(-sum) : 62'(sum);
        sum_rnd = sum_mag + 62'd32768;
        q_mag = sum_rnd[61:16];
        if (sum[61]) begin
            if (q_mag > 46'd2147483648) vel_sat = 32'sh8000_0000;
            else                        vel_sat = 32'(-$signed({1'b0, q_mag}));
        end else begin
            if (q_mag > 46'd2147483647) vel_sat = 32'sh7fff_ffff;
            else                        vel_sat = $signed(q_mag[31:0]);
        end
    end

    // history pointers
    logic [CW:0] tail_sum;
    logic [HW-1:0] wr_addr, head_inc;
    logic full;
    assign full = (count_reg >= CW'(HISTORY_DEPTH));
    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign head_inc = (head_reg == HW'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    always_comb begin
        if (full) wr_addr = head_reg;
        else if (tail_sum >= (CW+1)'(HISTORY_DEPTH))
            wr_addr = HW'(tail_sum - (CW+1)'(HISTORY_DEPTH));
        else wr_addr = HW'(tail_sum);
    end

    assign sts.hist_empty = (count_reg == '0);
    assign sts.spike = (count_reg != '0) && (52'(prod_move_reg) > prod_lim_reg);
    assign sts.expired = ((t_reg - rd_time_reg) > {12'd0, cfg.window_us});
    assign sts.last_entry = (count_reg == CW'(1));
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.walk_rd) begin
            rd_time_reg  <= hist_time[head_reg];
            rd_angle_reg <= hist_angle[head_reg];
        end
        if (cmd.commit) begin
            hist_time[wr_addr]  <= t_reg;
            hist_angle[wr_addr] <= a_reg;
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg <= a_new;
            t_reg <= s_data.timestamp_us;
        end
        if (cmd.spk_mul) begin
            prod_move_reg <= 34'(dmag_last) * 34'(eave_pkg::US_PER_S);
            prod_lim_reg  <= 52'(cfg.max_speed) * 52'(dt_last);
        end
        if (cmd.base_self) begin
            base_time_reg  <= t_reg - 32'd1;
            base_angle_reg <= a_reg;
        end
        if (cmd.walk_chk) begin
            base_time_reg  <= rd_time_reg;
            base_angle_reg <= rd_angle_reg;
        end
        if (cmd.rate_mul) begin
            num_reg  <= NW'(dmag_base) * NW'(eave_pkg::RATE_SCALE);
            dt_reg   <= dt_base;
            neg_reg  <= d_base[DW-1];
            zero_reg <= (d_base == '0);
            rem_reg  <= '0;
        end
        if (cmd.div_prep) num_reg <= num_reg + NW'(dt_reg >> 1);
        if (cmd.div_step) begin
            rem_reg <= q_bit ? (rem_sh - {1'b0, dt_reg}) : rem_sh;
            num_reg <= {num_reg[NW-2:0], q_bit};
        end
        if (cmd.blend_prep) begin
            diff_reg  <= (NW+2)'(rate) - (NW+2)'(last_vel_reg);
            alpha_reg <= cfg.smoothing_alpha[eave_pkg::ALPHA_W-1] ? eave_pkg::ALPHA_ONE
                                                                   : cfg.smoothing_alpha;
            acc_reg   <= '0;
        end
        if (cmd.blend_step) begin
            acc_reg   <= (acc_reg <<< 1) + (alpha_reg[eave_pkg::ALPHA_W-1] ? 61'(diff_reg) : 61'sd0);
            alpha_reg <= alpha_reg << 1;
        end
        if (cmd.finish) vel_reg <= vel_sat;
        if (cmd.commit) begin
            m_data_reg.angle    <= a_reg;
            m_data_reg.velocity <= vel_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg  <= '0;
            last_angle_reg <= '0;
            last_vel_reg   <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.walk_chk && sts.expired) begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.commit) begin
                last_time_reg  <= t_reg;
                last_angle_reg <= a_reg;
                last_vel_reg   <= vel_reg;
                if (full) head_reg <= head_inc;
                else      count_reg <= count_reg + 1'b1;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end
endmodule

/* dv/encoder_angle_velocity_estimator_tb.sv */
`timescale 1ns / 1ps

module encoder_angle_velocity_estimator_tb;

    localparam int HIST_N = 64;
    localparam int CYCLE_LIMIT = 2000000;

    // register indexes
    localparam int REG_ZERO   = 0;
    localparam int REG_REV    = 1;
    localparam int REG_CARRY  = 2;
    localparam int REG_MAXSPD = 3;
    localparam int REG_WINDOW = 4;
    localparam int REG_ALPHA  = 5;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    eave_pkg::in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    eave_pkg::out_word_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    encoder_angle_velocity_estimator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // predictor copy of the registers and estimator state
    logic [11:0] p_zero;
    logic        p_rev;
    logic [12:0] p_carry;
    logic [19:0] p_maxspd;
    logic [19:0] p_window;
    logic [16:0] p_alpha;
    logic [31:0] st_last_time;
    logic signed [31:0] st_last_angle;
    logic signed [31:0] st_last_vel;
    logic [31:0] hist_t [HIST_N];
    logic signed [31:0] hist_a [HIST_N];
    int unsigned st_head, st_count;

    eave_pkg::in_word_t  sample_q[$];     // words waiting for the driver
    eave_pkg::out_word_t estimate_q[$];   // predicted results, oldest first
    int fail_cnt = 0;
    int cycle_cnt = 0;
    bit idle_off = 1'b0;        // no gaps in the last part of the run
    bit feeding = 1'b0;
    int s_gap = 0, m_gap = 0;

    function automatic longint unwrap_delta(longint d);
        longint mag;
        mag = d < 0 ? -d : d;
        if (mag > longint'(p_carry)) d += (d > 0) ? -4096 : 4096;
        return d;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    // applies one accepted sample to the predictor state
    task automatic estimate_sample(eave_pkg::in_word_t w);
        longint a, d, delta, rate, alpha, vsum, v;
        longint unsigned dmag, dt;
        logic [31:0] t, base_t, dt32;
        longint base_a;
        int unsigned idx;
        eave_pkg::out_word_t r;
        t = w.timestamp_us;
        a = longint'(w.raw_angle) - longint'(p_zero);
        if (a < 0) a += 4096;
        if (p_rev) a = 4096 - a;
        if (st_count != 0) begin
            d = unwrap_delta(a - st_last_angle);
            dmag = d < 0 ? -d : d;
            dt32 = t - st_last_time;
            dt = 64'(dt32);
            if (dmag * 1000000 > 64'(p_maxspd) * dt) return;   // spike dropped
        end
        base_t = t - 1;
        base_a = a;
        while (st_count != 0) begin
            idx = st_head % HIST_N;
            base_t = hist_t[idx];
            base_a = hist_a[idx];
            if ((t - base_t) <= 32'(p_window)) break;
            st_head = (st_head + 1) % HIST_N;
            st_count--;
        end
        delta = unwrap_delta(a - base_a);
        dt32 = t - base_t;
        if (dt32 == 0)
            rate = delta > 0 ? 64'sd2147483647 : (delta < 0 ? -64'sd2147483648 : 0);
        else
            rate = round_div(delta * 256 * 1000000, longint'(dt32));
        alpha = p_alpha > 17'd65536 ? 65536 : longint'(p_alpha);
        vsum = alpha * rate + (65536 - alpha) * longint'(st_last_vel);
        v = round_div(vsum, 65536);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        st_last_time = t;
        st_last_angle = a;
        st_last_vel = 32'(v);
        if (st_count >= HIST_N) begin
            idx = st_head % HIST_N;
            st_head = (st_head + 1) % HIST_N;
        end else begin
            idx = (st_head + st_count) % HIST_N;
            st_count++;
        end
        hist_t[idx] = t;
        hist_a[idx] = a;
        r.angle = 13'(a);
        r.velocity = 32'(v);
        estimate_q.push_back(r);
    endtask

    // driver: input words with random gaps
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            estimate_sample(s_data);
            sample_q.delete(0);
        end
        if (s_valid && !s_ready) begin
            // hold the word
        end else if (s_gap > 0) begin
            s_gap <= s_gap - 1;
            s_valid <= 1'b0;
        end else begin
            // accepted word already removed above, so look at the current head
            if (feeding && sample_q.size() > 0 && (idle_off || $urandom_range(0, 5) != 0)) begin
                s_valid <= 1'b1;
                s_data <= sample_q[0];
            end else begin
                s_valid <= 1'b0;
                if (!idle_off && feeding) s_gap <= $urandom_range(1, 5);
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        eave_pkg::out_word_t exp_w;
        cycle_cnt <= cycle_cnt + 1;
        if (m_valid && m_ready) begin
            if (estimate_q.size() == 0) begin
                $display("%0t: result with none expected: angle %0d velocity %0d",
                         $time, m_data.angle, m_data.velocity);
                fail_cnt++;
            end else begin
                exp_w = estimate_q[0];
                estimate_q.delete(0);
                if (m_data.angle !== exp_w.angle) begin
                    $display("%0t: angle expected %0d actual %0d",
                             $time, exp_w.angle, m_data.angle);
                    fail_cnt++;
                end
                if (m_data.velocity !== exp_w.velocity) begin
                    $display("%0t: velocity expected %0d actual %0d",
                             $time, exp_w.velocity, m_data.velocity);
                    fail_cnt++;
                end
            end
        end
        if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_ready <= 1'b0;
        end else if (!idle_off && aresetn && $urandom_range(0, 7) == 0) begin
            m_gap <= $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // register write through the apb port, block idle
    task automatic reg_write(int idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 5'(4 * idx); pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_ZERO:   p_zero   = val[11:0];
            REG_REV:    p_rev    = val[0];
            REG_CARRY:  p_carry  = val[12:0];
            REG_MAXSPD: p_maxspd = val[19:0];
            REG_WINDOW: p_window = val[19:0];
            REG_ALPHA:  p_alpha  = val[16:0];
            default: ;
        endcase
    endtask

    // run the queued words and wait for the block to settle
    task automatic run_phase();
        int guard;
        feeding = 1'b1;
        guard = 0;
        while ((sample_q.size() != 0 || estimate_q.size() != 0 || s_valid) && guard < 1000000) begin
            @(posedge aclk);
            guard++;
        end
        feeding = 1'b0;
        // a dropped word may still be in flight
        repeat (300) @(posedge aclk);
    endtask

    logic [31:0] t_now;

    task automatic add_word(logic [11:0] ang, logic [31:0] step);
        eave_pkg::in_word_t w;
        t_now = t_now + step;
        w.raw_angle = ang;
        w.timestamp_us = t_now;
        sample_q.push_back(w);
    endtask

    // smooth rotation with random content, some spikes and jumps mixed in
    task automatic add_motion(int n);
        int pos, spd;
        pos = $urandom_range(0, 4095);
        spd = int'($urandom_range(0, 60)) - 30;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 4095);
            else pos = pos + spd + int'($urandom_range(0, 4)) - 2;
            case ($urandom_range(0, 9))
                0: add_word(12'(pos), $urandom());
                1: add_word(12'(pos), 32'($urandom_range(0, 3)));
                default: add_word(12'(pos), 32'($urandom_range(200, 6000)));
            endcase
        end
    endtask

    initial begin
        p_zero = 0; p_rev = 1; p_carry = 3686; p_maxspd = 20480;
        p_window = 20000; p_alpha = 55706;
        st_last_time = 0; st_last_angle = 0; st_last_vel = 0;
        st_head = 0; st_count = 0;
        t_now = 32'hFFFF_F000;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, extremes of the fields, timestamp wrap
        add_word(12'd0, 32'd0);
        add_word(12'd4095, 32'd1000);
        add_word(12'd4095, 32'd0);          // zero time step, no motion
        add_word(12'd10, 32'd0);            // zero time step with motion: spike
        add_word(12'd2048, 32'd5000);
        add_word(12'd2050, 32'd6000);       // crosses the 32-bit time wrap
        add_word(12'd2060, 32'd40000);      // long time step, still a spike
        run_phase();

        // open limits: widest speed limit, alpha of one, no unwrap
        reg_write(REG_ZERO, 32'd4095);
        reg_write(REG_REV, 32'd0);
        reg_write(REG_CARRY, 32'd4096);
        reg_write(REG_MAXSPD, 32'hFFFFF);
        reg_write(REG_WINDOW, 32'd1000000);
        reg_write(REG_ALPHA, 32'd65536);
        add_word(12'd0, 32'd7);
        add_word(12'd4095, 32'd1);
        add_word(12'd0, 32'd0);             // zero time step with motion: spike
        add_word(12'd100, 32'hFFFF_FFFF);
        add_word(12'd4000, 32'd3);
        for (int i = 0; i < 70; i++) add_word(12'(i * 37), 32'd2);   // fast steps: nearly all dropped as spikes
        run_phase();

        // tight limits: zero window, zero threshold, alpha zero then above one
        reg_write(REG_WINDOW, 32'd0);
        reg_write(REG_CARRY, 32'd0);
        reg_write(REG_ALPHA, 32'd0);
        reg_write(REG_MAXSPD, 32'd0);
        add_word(12'd5, 32'd10);
        add_word(12'd5, 32'd10);
        add_word(12'd6, 32'd10);
        reg_write(REG_ALPHA, 32'h1FFFF);
        run_phase();

        // random phases through several settings
        for (int ph = 0; ph < 6; ph++) begin
            reg_write(REG_ZERO, $urandom_range(0, 4095));
            reg_write(REG_REV, $urandom_range(0, 1));
            reg_write(REG_CARRY, ph == 0 ? 4096 : $urandom_range(1500, 4096));
            reg_write(REG_MAXSPD, ph == 1 ? 32'hFFFFF : $urandom_range(20000, 1048575));
            reg_write(REG_WINDOW, ph == 2 ? 1000000 : $urandom_range(0, 40000));
            reg_write(REG_ALPHA, ph == 3 ? 65536 : $urandom_range(0, 131071));
            if (ph == 5) idle_off = 1'b1;
            add_motion(80);
            run_phase();
        end

        if (fail_cnt == 0 && sample_q.size() == 0 && estimate_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
src/eave_pkg.sv
src/eave_cfg.sv
src/eave_ctrl.sv
src/eave_dp.sv
src/encoder_angle_velocity_estimator.sv
dv/encoder_angle_velocity_estimator_tb.sv
